// ===== rtl/rtdavg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdavg_pkg
// Shared widths, register indexes, microcode control word and the program
// table for the ratiometric RTD temperature averager.
// ----------------------------------------------------------------------------
package rtdavg_pkg;

   // field widths
   localparam int TAP_W      = 12;
   localparam int REF_W      = 10;
   localparam int NOM_W      = 10;
   localparam int SLOPE_W    = 16;
   localparam int TEMP_W     = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // datapath widths
   localparam int DIFF_W  = TAP_W + 1;
   localparam int ACC_W   = 44;
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = SLOPE_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // divider loop
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = 4;

   // register reset values
   localparam logic [REF_W-1:0]   REF_OHMS_RESET  = 10'd100;
   localparam logic [NOM_W-1:0]   NOM_OHMS_RESET  = 10'd100;
   localparam logic [SLOPE_W-1:0] SLOPE_Q12_RESET = 16'd10639;

   // saturation limits and quotient offset
   localparam logic [TEMP_W-1:0] TEMP_MAX    = 16'h7FFF;
   localparam logic [TEMP_W-1:0] TEMP_MIN    = 16'h8000;
   localparam logic [TEMP_W-1:0] QUOT_OFFSET = 16'h8000;

   // register indexes
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_REFERENCE_OHMS = 2'd0;
   localparam csr_index_type CSR_NOMINAL_OHMS   = 2'd1;
   localparam csr_index_type CSR_SLOPE_Q12      = 2'd2;

   // program addresses
   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;
   localparam pc_type STEP_WAIT      = 4'd0;
   localparam pc_type STEP_MUL_SR    = 4'd1;
   localparam pc_type STEP_MUL_NR    = 4'd2;
   localparam pc_type STEP_MUL_SLOPE = 4'd3;
   localparam pc_type STEP_BIAS_TEMP = 4'd4;
   localparam pc_type STEP_SAT_CHECK = 4'd5;
   localparam pc_type STEP_DIV_TEMP  = 4'd6;
   localparam pc_type STEP_TAKE_TEMP = 4'd7;
   localparam pc_type STEP_RING_READ = 4'd8;
   localparam pc_type STEP_RING_UPD  = 4'd9;
   localparam pc_type STEP_BIAS_AVG  = 4'd10;
   localparam pc_type STEP_DIV_AVG   = 4'd11;
   localparam pc_type STEP_TAKE_AVG  = 4'd12;
   localparam pc_type STEP_EMIT      = 4'd13;

   typedef enum logic [1:0] {
      MUL_SR,
      MUL_NR,
      MUL_SLOPE
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_SUB,
      ACC_BIAS_TEMP,
      ACC_BIAS_AVG,
      ACC_DIV,
      ACC_RECIP
   } acc_op_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_WAIT_IN,
      JMP_SAT,
      JMP_LOOP,
      JMP_WAIT_OUT
   } jump_type;

   typedef struct packed {
      logic        accept;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        sat_take;
      logic        take_now;
      logic        mem_read;
      logic        ring_update;
      logic        take_avg;
      logic        emit;
      jump_type    jump;
      pc_type      target;
   } ctrl_word_type;

   typedef struct packed {
      logic in_fire;
      logic fault;
      logic sat;
      logic out_free;
   } seq_status_type;

   // microcode program
   function automatic ctrl_word_type rom_word(input pc_type pc);
      ctrl_word_type w;
      w.accept      = 1'b0;
      w.mul_sel     = MUL_SR;
      w.acc_op      = ACC_HOLD;
      w.sat_take    = 1'b0;
      w.take_now    = 1'b0;
      w.mem_read    = 1'b0;
      w.ring_update = 1'b0;
      w.take_avg    = 1'b0;
      w.emit        = 1'b0;
      w.jump        = JMP_NEXT;
      w.target      = STEP_WAIT;
      case (pc)
         STEP_WAIT: begin
            w.accept = 1'b1;
            w.jump   = JMP_WAIT_IN;
            w.target = STEP_BIAS_AVG;
         end
         STEP_MUL_SR: begin
            w.mul_sel = MUL_SR;
            w.acc_op  = ACC_LOAD;
         end
         STEP_MUL_NR: begin
            w.mul_sel = MUL_NR;
            w.acc_op  = ACC_SUB;
         end
         STEP_MUL_SLOPE: begin
            w.mul_sel = MUL_SLOPE;
            w.acc_op  = ACC_LOAD;
         end
         STEP_BIAS_TEMP: begin
            w.acc_op = ACC_BIAS_TEMP;
         end
         STEP_SAT_CHECK: begin
            w.sat_take = 1'b1;
            w.jump     = JMP_SAT;
            w.target   = STEP_RING_READ;
         end
         STEP_DIV_TEMP: begin
            w.acc_op = ACC_DIV;
            w.jump   = JMP_LOOP;
         end
         STEP_TAKE_TEMP: begin
            w.take_now = 1'b1;
         end
         STEP_RING_READ: begin
            w.mem_read = 1'b1;
         end
         STEP_RING_UPD: begin
            w.ring_update = 1'b1;
         end
         STEP_BIAS_AVG: begin
            w.acc_op = ACC_BIAS_AVG;
         end
         // window mean by one reciprocal multiply
         STEP_DIV_AVG: begin
            w.acc_op = ACC_RECIP;
         end
         STEP_TAKE_AVG: begin
            w.take_avg = 1'b1;
         end
         STEP_EMIT: begin
            w.emit   = 1'b1;
            w.jump   = JMP_WAIT_OUT;
            w.target = STEP_WAIT;
         end
         default: begin
            w.jump   = JMP_WAIT_OUT;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/rtdavg_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdavg_seq
// Microcode sequencer: program counter, divider loop counter and the
// program table; hands the current control word to the datapath.
// ----------------------------------------------------------------------------
module rtdavg_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  rtdavg_pkg::seq_status_type status,
   output rtdavg_pkg::ctrl_word_type  ctrl
);
   import rtdavg_pkg::*;

   pc_type               pc_ff, pc_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // control word for this step
   assign ctrl = rom_word(pc_ff);

   // next step and loop count
   always_comb begin
      pc_in  = pc_ff + 1'b1;
      cnt_in = '0;
      case (ctrl.jump)
         JMP_NEXT: begin
            pc_in = pc_ff + 1'b1;
         end
         JMP_WAIT_IN: begin
            if (!status.in_fire) begin
               pc_in = pc_ff;
            end else if (status.fault) begin
               pc_in = ctrl.target;
            end
         end
         JMP_SAT: begin
            if (status.sat) begin
               pc_in = ctrl.target;
            end
         end
         JMP_LOOP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != DIV_CNT_W'(DIV_STEPS - 1)) begin
               pc_in = pc_ff;
            end
         end
         JMP_WAIT_OUT: begin
            pc_in = status.out_free ? ctrl.target : pc_ff;
         end
         default: begin
            pc_in = STEP_WAIT;
         end
      endcase
   end

   // step registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= STEP_WAIT;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/rtd_ratiometric_temp_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_ratiometric_temp_average
// Ratiometric RTD temperature from three ADC taps, rounded and saturated to
// signed 1/16 degree, kept in a ring of WINDOW_DEPTH samples whose floored
// mean is reported with each result.
//
//   channel  dir  fields (lowest bit up)
//   req_     in   tdata: base_tap[11:0], mid_tap[23:12], top_tap[35:24]
//   rsp_     out  tdata: temp_now[15:0], temp_average[31:16]; tuser: ratio_fault
//   csr_     in   0 reference_ohms, 1 nominal_ohms, 2 slope_q12
//
// A new beat is accepted only in the wait step, after the previous result is
// registered; the 16-step restoring divider for the temperature is skipped
// on saturation or a ratio fault, the window mean takes one reciprocal multiply.
// Synchronous reset clears ring valid bits, sum, slot, tvalid; presets CSRs.
// A stalled result beat holds the sequencer in its final step only.
// ----------------------------------------------------------------------------
module rtd_ratiometric_temp_average #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // base_tap, mid_tap, top_tap
   input  logic [rtdavg_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // temp_now, temp_average
   output logic [rtdavg_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // ratio_fault
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_we,
   input  logic [rtdavg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rtdavg_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rtdavg_pkg::*;

   localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int TOTAL_W = TEMP_W + SLOT_W;
   localparam logic [ACC_W-1:0] AVG_BIAS = ACC_W'(32768 * WINDOW_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

   // reciprocal of the window depth, exact for every biased window sum
   localparam int AVG_K      = TOTAL_W + SLOT_W;
   localparam int AVG_R_W    = TOTAL_W + 1;
   localparam int AVG_PROD_W = TOTAL_W + AVG_R_W;
   localparam logic [AVG_R_W-1:0] AVG_RECIP =
      AVG_R_W'(((64'd1 << AVG_K) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

   ctrl_word_type  ctrl;
   seq_status_type status;

   // configuration
   logic [REF_W-1:0]   ref_ohms_ff;
   logic [NOM_W-1:0]   nom_ohms_ff;
   logic [SLOPE_W-1:0] slope_ff;

   // input unpack
   logic [TAP_W-1:0]  base_tap, mid_tap, top_tap;
   logic              req_fire, req_fault;

   // datapath
   logic signed [DIFF_W-1:0]  sens_ff;
   logic        [TAP_W-1:0]   refd_ff;
   logic                      fault_ff;
   logic        [ACC_W-1:0]   acc_ff, acc_in;
   logic        [ACC_W-1:0]   dsr_ff, dsr_in;
   logic        [TEMP_W-1:0]  quo_ff, quo_in;
   logic signed [TEMP_W-1:0]  now_ff, now_in;
   logic        [TEMP_W-1:0]  avg_ff;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [AVG_PROD_W-1:0]     avg_prod;
   logic                      sat_low, sat_high, div_ge;

   // window store
   logic signed [TEMP_W-1:0]  ring [WINDOW_DEPTH];
   logic signed [TEMP_W-1:0]  ring_rd_ff, old_sample;
   logic [WINDOW_DEPTH-1:0]   valid_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic signed [TOTAL_W-1:0] total_ff;

   // result register
   logic [TEMP_W-1:0] rsp_now_ff, rsp_avg_ff;
   logic              rsp_fault_ff, rsp_valid_ff, out_free;

   rtdavg_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign base_tap   = req_tdata[TAP_W-1:0];
   assign mid_tap    = req_tdata[2*TAP_W-1:TAP_W];
   assign top_tap    = req_tdata[3*TAP_W-1:2*TAP_W];
   assign req_tready = ctrl.accept;
   assign req_fire   = req_tvalid & req_tready;
   assign req_fault  = (mid_tap <= base_tap);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign status.in_fire  = req_fire;
   assign status.fault    = req_fault;
   assign status.sat      = sat_low | sat_high;
   assign status.out_free = out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ohms_ff <= REF_OHMS_RESET;
         nom_ohms_ff <= NOM_OHMS_RESET;
         slope_ff    <= SLOPE_Q12_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REFERENCE_OHMS: ref_ohms_ff <= csr_wdata[REF_W-1:0];
            CSR_NOMINAL_OHMS:   nom_ohms_ff <= csr_wdata[NOM_W-1:0];
            CSR_SLOPE_Q12:      slope_ff    <= csr_wdata[SLOPE_W-1:0];
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (ctrl.mul_sel)
         MUL_SR: begin
            mul_a = MUL_A_W'(sens_ff);
            mul_b = $signed({{(MUL_B_W-REF_W){1'b0}}, ref_ohms_ff});
         end
         MUL_NR: begin
            mul_a = $signed({{(MUL_A_W-TAP_W){1'b0}}, refd_ff});
            mul_b = $signed({{(MUL_B_W-NOM_W){1'b0}}, nom_ohms_ff});
         end
         MUL_SLOPE: begin
            mul_a = $signed(acc_ff[MUL_A_W-1:0]);
            mul_b = $signed({1'b0, slope_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // window mean: biased sum times the depth reciprocal
   assign avg_prod = AVG_PROD_W'(acc_ff[TOTAL_W-1:0]) * AVG_PROD_W'(AVG_RECIP);

   // saturation test and divider compare
   assign sat_low  = acc_ff[ACC_W-1];
   assign sat_high = !sat_low && (acc_ff >= (dsr_ff << 1));
   assign div_ge   = (acc_ff >= dsr_ff);

   // accumulator, divisor and quotient
   always_comb begin
      acc_in = acc_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      case (ctrl.acc_op)
         ACC_HOLD: ;
         ACC_LOAD: acc_in = ACC_W'(prod);
         ACC_SUB:  acc_in = acc_ff - ACC_W'(prod);
         ACC_BIAS_TEMP: begin
            // 2*num + half divisor + 32768 divisors, divisor = refd * 512
            acc_in = (acc_ff << 1) + (ACC_W'(refd_ff) << 8) + (ACC_W'(refd_ff) << 24);
            dsr_in = ACC_W'(refd_ff) << 24;
            quo_in = '0;
         end
         ACC_BIAS_AVG: begin
            acc_in = {{(ACC_W-TOTAL_W){total_ff[TOTAL_W-1]}}, total_ff} + AVG_BIAS;
         end
         ACC_DIV: begin
            if (div_ge) begin
               acc_in = acc_ff - dsr_ff;
            end
            dsr_in = dsr_ff >> 1;
            quo_in = {quo_ff[TEMP_W-2:0], div_ge};
         end
         ACC_RECIP: begin
            quo_in = avg_prod[AVG_K +: TEMP_W];
         end
         default: ;
      endcase
   end

   // current sample value
   always_comb begin
      now_in = now_ff;
      if (req_fire) begin
         now_in = '0;
      end else if (ctrl.sat_take && sat_low) begin
         now_in = $signed(TEMP_MIN);
      end else if (ctrl.sat_take && sat_high) begin
         now_in = $signed(TEMP_MAX);
      end else if (ctrl.take_now) begin
         now_in = $signed(quo_ff ^ QUOT_OFFSET);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sens_ff  <= $signed({1'b0, top_tap}) - $signed({1'b0, mid_tap});
         refd_ff  <= mid_tap - base_tap;
         fault_ff <= req_fault;
      end
      if (ctrl.take_avg) begin
         avg_ff <= quo_ff ^ QUOT_OFFSET;
      end
      acc_ff <= acc_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      now_ff <= now_in;
   end

   // ring memory, registered read
   always_ff @(posedge clock) begin
      if (ctrl.mem_read) begin
         ring_rd_ff <= ring[slot_ff];
      end
      if (ctrl.ring_update) begin
         ring[slot_ff] <= now_ff;
      end
   end

   assign old_sample = valid_ff[slot_ff] ? ring_rd_ff : '0;

   // window sum, slot pointer and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         slot_ff  <= '0;
         total_ff <= '0;
      end else if (ctrl.ring_update) begin
         valid_ff[slot_ff] <= 1'b1;
         slot_ff  <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
         total_ff <= total_ff + TOTAL_W'(now_ff) - TOTAL_W'(old_sample);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit && out_free) begin
         rsp_now_ff   <= now_ff;
         rsp_avg_ff   <= avg_ff;
         rsp_fault_ff <= fault_ff;
      end
   end

   assign rsp_tdata  = {rsp_avg_ff, rsp_now_ff};
   assign rsp_tuser  = rsp_fault_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule
